/* design/i2cm_pkg.sv */
// Package for the I2C master transfer sequencer: request/response payload
// types, phase and completion codes, status bit positions.
// No dependencies.
package i2cm_pkg;

  localparam int unsigned MAX_TRANSFER      = 8192;
  localparam int unsigned MAX_SUBADDR_BYTES = 2;

  localparam logic [13:0] MaxTransferW = 14'(MAX_TRANSFER);
  localparam logic [1:0]  MaxSubaddrW  = 2'(MAX_SUBADDR_BYTES);

  // status_bits positions
  localparam int unsigned StBed  = 0;  // bus error
  localparam int unsigned StSsd  = 1;  // stop seen
  localparam int unsigned StAld  = 2;  // arbitration lost
  localparam int unsigned StIrf  = 3;  // receive full
  localparam int unsigned StNak  = 4;
  localparam int unsigned StIdle = 5;  // lines idle
  localparam int unsigned StUb   = 6;  // unit busy
  localparam int unsigned StIbb  = 7;  // bus busy

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_EVENT = 2'd1,
    REQ_STOP  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DONE    = 3'd1,
    PH_FAILED  = 3'd2,
    PH_ADDRESS = 3'd3,
    PH_SUBADDR = 3'd4,
    PH_READ    = 3'd5,
    PH_WRITE   = 3'd6,
    PH_HALTING = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    CC_BUSY    = 3'd0,
    CC_OK      = 3'd1,
    CC_ARB     = 3'd2,
    CC_BUS_ERR = 3'd3,
    CC_ABORTED = 3'd4,
    CC_OTHER   = 3'd5
  } cc_e;

  // sequencer state machine, one-hot
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DONE    = 8'b0000_0010,
    S_FAILED  = 8'b0000_0100,
    S_ADDRESS = 8'b0000_1000,
    S_SUBADDR = 8'b0001_0000,
    S_READ    = 8'b0010_0000,
    S_WRITE   = 8'b0100_0000,
    S_HALTING = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  device_address;
    logic        read_not_write;
    logic [1:0]  subaddress_bytes;
    logic [15:0] subaddress;
    logic [13:0] byte_count;
    logic [7:0]  next_tx_byte;
    logic [7:0]  received_byte;
    logic [7:0]  status_bits;
  } req_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] data_out;
    logic       data_load;
    logic       send_start;
    logic       send_stop;
    logic       send_nak;
    logic       transfer_byte;
    logic       master_abort;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic [2:0] completion_code;
  } rsp_t;

  typedef struct packed {
    state_e      phase;
    logic [6:0]  target;
    logic        reading;
    logic [4:0]  sa_bits_left;
    logic [15:0] offset;
    logic [13:0] bytes_left;
  } seq_state_t;

  function automatic phase_e phase_code(state_e s);
    phase_e p;
    unique case (s)
      S_IDLE:    p = PH_IDLE;
      S_DONE:    p = PH_DONE;
      S_FAILED:  p = PH_FAILED;
      S_ADDRESS: p = PH_ADDRESS;
      S_SUBADDR: p = PH_SUBADDR;
      S_READ:    p = PH_READ;
      S_WRITE:   p = PH_WRITE;
      S_HALTING: p = PH_HALTING;
      default:   p = PH_IDLE;
    endcase
    return p;
  endfunction

endpackage

/* design/i2cm_req_if.sv */
// Request channel of the I2C master transfer sequencer.
// Depends on i2cm_pkg for the payload type.
interface i2cm_req_if import i2cm_pkg::*; ;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/i2cm_rsp_if.sv */
// Response channel of the I2C master transfer sequencer.
// Depends on i2cm_pkg for the payload type.
interface i2cm_rsp_if import i2cm_pkg::*; ;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/i2c_master_transfer_sequencer.sv */
// Top level of the I2C master transfer sequencer: request register, step
// logic, sequencer state and response register. Uses i2cm_pkg, i2cm_req_if,
// i2cm_rsp_if and i2cm_step.
//
//   channel  direction  payload  purpose
//   req_i    in         req_t    start / byte-done event / stop request
//   rsp_o    out        rsp_t    byte-unit commands, phase, completion code
//
// One response per request. A request is held in the request register, then
// its response is held in the response register; a new request can be taken
// every cycle while the response is not stalled. The sequencer state updates
// when the request moves to the response register. A stalled response holds
// the request register, which then accepts nothing until it drains. Reset
// puts the sequencer in idle with all counters cleared.
module i2c_master_transfer_sequencer import i2cm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  i2cm_req_if.sink  req_i,
  i2cm_rsp_if.source rsp_o
);

  logic       in_valid_q, in_valid_d;
  req_t       req_q;
  logic       out_valid_q, out_valid_d;
  rsp_t       rsp_q;
  seq_state_t state_q, state_d;
  rsp_t       rsp_d;
  logic       advance;
  logic       accept;

  i2cm_step u_step (
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (rsp_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: S_IDLE, default: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i.data;
    if (advance) rsp_q <= rsp_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule

/* design/i2cm_step.sv */
// Next-state and byte-unit command logic for one request.
// Purely combinational; depends on i2cm_pkg.
module i2cm_step import i2cm_pkg::*; (
  input  seq_state_t state_i,
  input  req_t       req_i,
  output seq_state_t state_o,
  output rsp_t       rsp_o
);

  seq_state_t nxt;
  rsp_t       rsp;
  logic [7:0]  st;
  logic [13:0] n_sat;
  logic [1:0]  sa_sat;
  logic [13:0] bl;
  logic [4:0]  sa_left;
  logic        go_write;
  logic        go_read;
  logic        busy_after;
  state_e      judged;

  assign st = req_i.status_bits;

  always_comb begin
    nxt      = state_i;
    rsp      = '0;
    go_write = 1'b0;
    go_read  = 1'b0;
    bl       = state_i.bytes_left;
    sa_left  = state_i.sa_bits_left - 5'd8;
    n_sat    = (req_i.byte_count > MaxTransferW) ? MaxTransferW : req_i.byte_count;
    sa_sat   = (req_i.subaddress_bytes > MaxSubaddrW) ? MaxSubaddrW : req_i.subaddress_bytes;

    case (req_i.req_type)
      REQ_START: begin
        nxt.target       = req_i.device_address;
        nxt.reading      = req_i.read_not_write;
        nxt.offset       = req_i.subaddress;
        nxt.bytes_left   = n_sat;
        nxt.sa_bits_left = {sa_sat, 3'b000};
        if (n_sat == '0) begin
          nxt.phase = S_DONE;
        end else begin
          // subaddressed reads start as a write, readdress comes later
          if (sa_sat != '0) begin
            nxt.phase    = S_SUBADDR;
            rsp.data_out = {req_i.device_address, 1'b0};
          end else begin
            nxt.phase    = S_ADDRESS;
            rsp.data_out = {req_i.device_address, req_i.read_not_write};
          end
          rsp.data_load     = 1'b1;
          rsp.send_start    = 1'b1;
          rsp.transfer_byte = 1'b1;
        end
      end
      REQ_EVENT: begin
        if (st[StBed] || st[StSsd]) begin
          nxt.phase = S_FAILED;
        end else begin
          unique case (state_i.phase)
            S_HALTING: nxt.phase = S_IDLE;
            S_SUBADDR: begin
              if (state_i.sa_bits_left >= 5'd8) begin
                nxt.sa_bits_left  = sa_left;
                rsp.data_out      = 8'(state_i.offset >> sa_left[3:0]);
                rsp.data_load     = 1'b1;
                rsp.transfer_byte = 1'b1;
              end else begin
                nxt.sa_bits_left = '0;
                if (state_i.reading) begin
                  rsp.data_out      = {state_i.target, 1'b1};
                  rsp.data_load     = 1'b1;
                  rsp.send_start    = 1'b1;
                  rsp.transfer_byte = 1'b1;
                  nxt.phase         = S_ADDRESS;
                end else begin
                  go_write = 1'b1;
                end
              end
            end
            S_ADDRESS: begin
              go_read  = state_i.reading;
              go_write = !state_i.reading;
            end
            S_READ: begin
              if (st[StIrf]) begin
                if (bl != '0) bl = bl - 14'd1;
                rsp.rx_data  = req_i.received_byte;
                rsp.rx_valid = 1'b1;
              end
              nxt.bytes_left = bl;
              if (bl == '0 || st[StNak] || st[StIdle]) nxt.phase = S_DONE;
              else go_read = 1'b1;
            end
            S_WRITE: begin
              if (bl == '0 || st[StNak]) nxt.phase = S_DONE;
              else go_write = 1'b1;
            end
            default: ;
          endcase
        end
      end
      REQ_STOP: begin
        if (state_i.phase != S_DONE && state_i.phase != S_IDLE) begin
          if (!st[StUb]) begin
            nxt.phase = S_IDLE;
          end else if (!st[StIbb] && state_i.phase != S_HALTING) begin
            nxt.phase        = S_HALTING;
            rsp.master_abort = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (go_read) begin
      if (bl == '0) begin
        nxt.phase = S_DONE;
      end else begin
        nxt.phase         = S_READ;
        rsp.transfer_byte = 1'b1;
        if (bl == 14'd1) begin
          rsp.send_stop = 1'b1;
          rsp.send_nak  = 1'b1;
        end
      end
    end
    if (go_write) begin
      if (bl == '0) begin
        nxt.phase = S_DONE;
      end else begin
        nxt.phase         = S_WRITE;
        rsp.data_out      = req_i.next_tx_byte;
        rsp.data_load     = 1'b1;
        rsp.transfer_byte = 1'b1;
        rsp.send_stop     = (bl == 14'd1);
        nxt.bytes_left    = bl - 14'd1;
      end
    end

    // a stop request reports on the phase it found
    busy_after = nxt.phase == S_ADDRESS || nxt.phase == S_SUBADDR ||
                 nxt.phase == S_READ || nxt.phase == S_WRITE ||
                 nxt.phase == S_HALTING;
    judged = (req_i.req_type == REQ_STOP) ? state_i.phase : nxt.phase;
    if (req_i.req_type != REQ_STOP && busy_after) begin
      rsp.completion_code = CC_BUSY;
    end else if (judged == S_DONE && !st[StAld] && !st[StBed]) begin
      rsp.completion_code = CC_OK;
    end else if (st[StAld]) begin
      rsp.completion_code = CC_ARB;
    end else if (st[StBed]) begin
      rsp.completion_code = CC_BUS_ERR;
    end else if (st[StSsd]) begin
      rsp.completion_code = CC_ABORTED;
    end else begin
      rsp.completion_code = CC_OTHER;
    end

    rsp.phase = phase_code(nxt.phase);
  end

  assign state_o = nxt;
  assign rsp_o   = rsp;

endmodule
